@@ design/tsr_pkg.sv @@
// Shared types and constants for the triangle span rasterizer.
// No dependencies; every other file in this folder uses it.
`timescale 1ns / 1ps
package tsr_pkg;

  localparam int XW        = 8;
  localparam int YW        = 6;
  localparam int X_MAX     = 255;
  localparam int Y_MAX     = 62;
  localparam int FRAC_BITS = 16;
  localparam int DIVW      = XW + FRAC_BITS;
  localparam int ACCW      = DIVW + 2;

  // which quantity the shared divider is producing
  typedef enum logic [1:0] {
    DIV_SPLIT = 2'd0,
    DIV_LSTEP = 2'd1,
    DIV_RSTEP = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     in_valid;
    logic [XW-1:0] ax;
    logic [YW-1:0] ay;
    logic [XW-1:0] bx;
    logic [YW-1:0] by;
    logic [XW-1:0] cx;
    logic [YW-1:0] cy;
    logic [7:0]    glyph;
    logic [7:0]    color;
  } tri_t;

  typedef struct packed {
    logic [YW-1:0] row;
    logic [XW-1:0] span_left;
    logic [XW-1:0] span_right;
    logic          span_empty;
    logic [7:0]    fill_glyph;
    logic [7:0]    fill_color;
    logic          last_span;
  } span_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     setup;
    logic     part_sel;
    logic     emit;
    logic     emit_flat;
    logic     last_part;
  } cmd_t;

  typedef struct packed {
    logic flat_all;
    logic flat_top;
    logic flat_bot;
    logic div_busy;
    logic div_done;
    logic walk_done;
    logic out_free;
  } stat_t;

endpackage

@@ design/tsr_tri_if.sv @@
// Handshake channel for triangle requests.
// Depends on tsr_pkg for field widths.
`timescale 1ns / 1ps
interface tsr_tri_if;
  logic                   valid;
  logic                   ready;
  logic [tsr_pkg::XW-1:0] ax;
  logic [tsr_pkg::YW-1:0] ay;
  logic [tsr_pkg::XW-1:0] bx;
  logic [tsr_pkg::YW-1:0] by;
  logic [tsr_pkg::XW-1:0] cx;
  logic [tsr_pkg::YW-1:0] cy;
  logic [7:0]             glyph;
  logic [7:0]             color;
  modport source (output valid, ax, ay, bx, by, cx, cy, glyph, color, input ready);
  modport sink (input valid, ax, ay, bx, by, cx, cy, glyph, color, output ready);
endinterface

@@ design/tsr_span_if.sv @@
// Handshake channel for span results.
// Depends on tsr_pkg for field widths.
`timescale 1ns / 1ps
interface tsr_span_if;
  logic                   valid;
  logic                   ready;
  logic [tsr_pkg::YW-1:0] row;
  logic [tsr_pkg::XW-1:0] span_left;
  logic [tsr_pkg::XW-1:0] span_right;
  logic                   span_empty;
  logic [7:0]             fill_glyph;
  logic [7:0]             fill_color;
  logic                   last_span;
  modport source (output valid, row, span_left, span_right, span_empty, fill_glyph,
                  fill_color, last_span, input ready);
  modport sink (input valid, row, span_left, span_right, span_empty, fill_glyph,
                fill_color, last_span, output ready);
endinterface

@@ design/tsr_div.sv @@
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on tsr_pkg for widths.
`timescale 1ns / 1ps
module tsr_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [tsr_pkg::DIVW-1:0] dividend,
  input  logic [tsr_pkg::YW-1:0]   divisor,
  output logic                     busy,
  output logic                     done,
  output logic [tsr_pkg::DIVW-1:0] quotient,
  output logic                     rem_nz
);
  localparam int CW = $clog2(tsr_pkg::DIVW);

  logic [tsr_pkg::YW-1:0]   rem;
  logic [tsr_pkg::YW-1:0]   dsr;
  logic [tsr_pkg::DIVW-1:0] quo;
  logic [CW-1:0]            cnt;
  logic [tsr_pkg::YW:0]     shifted;
  logic [tsr_pkg::YW+1:0]   diff;
  logic                     fits;

  // one trial subtraction
  always_comb begin
    shifted = {rem, quo[tsr_pkg::DIVW-1]};
    diff    = {1'b0, shifted} - {2'b00, dsr};
    fits    = ~diff[tsr_pkg::YW+1];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(tsr_pkg::DIVW - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // data
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[tsr_pkg::YW-1:0] : shifted[tsr_pkg::YW-1:0];
      quo <= {quo[tsr_pkg::DIVW-2:0], fits};
    end
  end

  assign quotient = quo;
  assign rem_nz   = |rem;
endmodule

@@ design/tsr_dp.sv @@
// Datapath: vertex sort, split point, edge slopes, x accumulators, span register.
// Depends on tsr_pkg and tsr_div.
`timescale 1ns / 1ps
module tsr_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  tsr_pkg::cmd_t        cmd,
  input  tsr_pkg::tri_t        tri_in,
  input  logic                 out_ready,
  output tsr_pkg::stat_t       stat,
  output logic                 out_valid,
  output tsr_pkg::span_t       span
);
  localparam int XW = tsr_pkg::XW;
  localparam int YW = tsr_pkg::YW;
  localparam int F  = tsr_pkg::FRAC_BITS;
  localparam int AW = tsr_pkg::ACCW;

  function automatic logic [XW-1:0] bound_of(input logic signed [AW-1:0] a);
    logic [AW-F-1:0] ip;
    begin
      ip = a[AW-1:F];
      if (a[AW-1]) return '0;
      else if (ip > (AW-F)'(tsr_pkg::X_MAX)) return XW'(tsr_pkg::X_MAX);
      else return ip[XW-1:0];
    end
  endfunction

  logic [XW-1:0] ix [3];
  logic [YW-1:0] iy [3];
  logic [XW-1:0] tx;
  logic [YW-1:0] ty;

  logic [XW-1:0] x0, x1, x2, sx, lx, rx, apex_x, ox;
  logic [YW-1:0] y0, y1, y2, nrows, k, row;
  logic [7:0]    glyph, color;
  logic          up, cur_neg;
  tsr_pkg::div_sel_t cur_sel;
  logic signed [AW-1:0] lacc, racc, lstep, rstep;

  logic [tsr_pkg::DIVW-1:0] dvd, quo;
  logic [YW-1:0]  dsr;
  logic           neg, rem_nz;
  logic           div_busy, div_done;
  logic [XW-1:0]  dmag;
  logic [YW-1:0]  dy_mid;
  logic [XW+YW-1:0] prod;
  logic [XW-1:0]  setup_lx, setup_rx, lo3, hi3;
  logic [XW+1:0]  sx_wide;
  logic [AW-1:0]  q_ext;

  // saturate y and sort by descending y
  always_comb begin
    tx = '0;
    ty = '0;
    ix[0] = tri_in.ax; ix[1] = tri_in.bx; ix[2] = tri_in.cx;
    iy[0] = (tri_in.ay > YW'(tsr_pkg::Y_MAX)) ? YW'(tsr_pkg::Y_MAX) : tri_in.ay;
    iy[1] = (tri_in.by > YW'(tsr_pkg::Y_MAX)) ? YW'(tsr_pkg::Y_MAX) : tri_in.by;
    iy[2] = (tri_in.cy > YW'(tsr_pkg::Y_MAX)) ? YW'(tsr_pkg::Y_MAX) : tri_in.cy;
    if (iy[0] < iy[1]) begin
      tx = ix[0]; ix[0] = ix[1]; ix[1] = tx;
      ty = iy[0]; iy[0] = iy[1]; iy[1] = ty;
    end
    if (iy[0] < iy[2]) begin
      tx = ix[0]; ix[0] = ix[2]; ix[2] = tx;
      ty = iy[0]; iy[0] = iy[2]; iy[2] = ty;
    end
    if (iy[1] < iy[2]) begin
      tx = ix[1]; ix[1] = ix[2]; ix[2] = tx;
      ty = iy[1]; iy[1] = iy[2]; iy[2] = ty;
    end
  end

  // divider operand selection
  always_comb begin
    dvd    = '0;
    dsr    = nrows;
    neg    = 1'b0;
    dmag   = '0;
    dy_mid = '0;
    prod   = '0;
    case (cmd.div_sel)
      tsr_pkg::DIV_SPLIT: begin
        neg    = x0 < x2;
        dmag   = neg ? x2 - x0 : x0 - x2;
        dy_mid = y1 - y2;
        prod   = {{XW{1'b0}}, dy_mid} * {{YW{1'b0}}, dmag};
        dvd    = {{(tsr_pkg::DIVW-XW-YW){1'b0}}, prod};
        dsr    = y0 - y2;
      end
      tsr_pkg::DIV_LSTEP: begin
        neg  = apex_x < lx;
        dmag = neg ? lx - apex_x : apex_x - lx;
        dvd  = {dmag, {F{1'b0}}};
      end
      tsr_pkg::DIV_RSTEP: begin
        neg  = apex_x < rx;
        dmag = neg ? rx - apex_x : apex_x - rx;
        dvd  = {dmag, {F{1'b0}}};
      end
      default: begin
        dvd = '0;
      end
    endcase
  end

  tsr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dsr),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quo),
    .rem_nz   (rem_nz)
  );

  // split x with floor rounding, slope with truncation toward zero
  always_comb begin
    sx_wide = cur_neg ? {2'b00, x2} - {2'b00, quo[XW-1:0]} - {{(XW+1){1'b0}}, rem_nz}
                      : {2'b00, x2} + {2'b00, quo[XW-1:0]};
    q_ext   = {{(AW-tsr_pkg::DIVW){1'b0}}, quo};
    ox       = stat.flat_top ? x0 : (stat.flat_bot ? x2 : sx);
    setup_lx = (x1 < ox) ? x1 : ox;
    setup_rx = (x1 < ox) ? ox : x1;
    lo3 = (x0 < x1) ? x0 : x1;
    lo3 = (x2 < lo3) ? x2 : lo3;
    hi3 = (x0 > x1) ? x0 : x1;
    hi3 = (x2 > hi3) ? x2 : hi3;
  end

  // status
  always_comb begin
    stat.flat_all  = y0 == y2;
    stat.flat_top  = y0 == y1;
    stat.flat_bot  = y1 == y2;
    stat.div_busy  = div_busy;
    stat.div_done  = div_done;
    stat.walk_done = k == nrows;
    stat.out_free  = ~out_valid | out_ready;
  end

  // triangle and walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x0 <= ix[0]; x1 <= ix[1]; x2 <= ix[2];
      y0 <= iy[0]; y1 <= iy[1]; y2 <= iy[2];
      glyph <= tri_in.glyph;
      color <= tri_in.color;
    end
    if (cmd.div_start) begin
      cur_sel <= cmd.div_sel;
      cur_neg <= neg;
    end
    if (div_done) begin
      case (cur_sel)
        tsr_pkg::DIV_SPLIT: sx <= sx_wide[XW-1:0];
        tsr_pkg::DIV_LSTEP: lstep <= cur_neg ? -$signed(q_ext) : $signed(q_ext);
        tsr_pkg::DIV_RSTEP: rstep <= cur_neg ? -$signed(q_ext) : $signed(q_ext);
        default: ;
      endcase
    end
    if (cmd.setup) begin
      lx     <= setup_lx;
      rx     <= setup_rx;
      apex_x <= cmd.part_sel ? x2 : x0;
      nrows  <= cmd.part_sel ? y1 - y2 : y0 - y1;
      up     <= ~cmd.part_sel;
      row    <= y1;
      k      <= '0;
      lacc   <= $signed({{(AW-tsr_pkg::DIVW){1'b0}}, setup_lx, {F{1'b0}}});
      racc   <= $signed({{(AW-tsr_pkg::DIVW){1'b0}}, setup_rx, {F{1'b0}}});
    end else if (cmd.emit) begin
      lacc <= lacc + lstep;
      racc <= racc + rstep;
      k    <= k + 1'b1;
      row  <= up ? row + 1'b1 : row - 1'b1;
    end
  end

  // span output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit | cmd.emit_flat) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      span.row        <= row;
      span.span_left  <= bound_of(lacc);
      span.span_right <= bound_of(racc);
      span.span_empty <= bound_of(lacc) > bound_of(racc);
      span.fill_glyph <= glyph;
      span.fill_color <= color;
      span.last_span  <= cmd.last_part & stat.walk_done;
    end else if (cmd.emit_flat) begin
      span.row        <= y0;
      span.span_left  <= lo3;
      span.span_right <= hi3;
      span.span_empty <= 1'b0;
      span.fill_glyph <= glyph;
      span.fill_color <= color;
      span.last_span  <= 1'b1;
    end
  end
endmodule

@@ design/tsr_ctl.sv @@
// Controller state machine that sequences divisions and span walks.
// Depends on tsr_pkg.
`timescale 1ns / 1ps
module tsr_ctl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  tsr_pkg::stat_t stat,
  output logic           in_ready,
  output tsr_pkg::cmd_t  cmd
);
  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_DECIDE = 10'b0000000010,
    S_SXWAIT = 10'b0000000100,
    S_SETUP  = 10'b0000001000,
    S_LDIV   = 10'b0000010000,
    S_LWAIT  = 10'b0000100000,
    S_RDIV   = 10'b0001000000,
    S_RWAIT  = 10'b0010000000,
    S_WALK   = 10'b0100000000,
    S_FLAT   = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic   part_sel, part_sel_next, last_part, last_part_next;

  // next state and commands
  always_comb begin
    state_next     = state;
    part_sel_next  = part_sel;
    last_part_next = last_part;
    cmd            = '0;
    cmd.div_sel    = tsr_pkg::DIV_SPLIT;
    cmd.part_sel   = part_sel;
    cmd.last_part  = last_part;
    in_ready       = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.flat_all) begin
          state_next = S_FLAT;
        end else if (stat.flat_top) begin
          part_sel_next  = 1'b1;
          last_part_next = 1'b1;
          state_next     = S_SETUP;
        end else if (stat.flat_bot) begin
          part_sel_next  = 1'b0;
          last_part_next = 1'b1;
          state_next     = S_SETUP;
        end else begin
          part_sel_next  = 1'b0;
          last_part_next = 1'b0;
          cmd.div_start  = 1'b1;
          state_next     = S_SXWAIT;
        end
      end
      S_SXWAIT: begin
        if (stat.div_done) state_next = S_SETUP;
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = S_LDIV;
      end
      S_LDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = tsr_pkg::DIV_LSTEP;
        state_next    = S_LWAIT;
      end
      S_LWAIT: begin
        if (stat.div_done) state_next = S_RDIV;
      end
      S_RDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = tsr_pkg::DIV_RSTEP;
        state_next    = S_RWAIT;
      end
      S_RWAIT: begin
        if (stat.div_done) state_next = S_WALK;
      end
      S_WALK: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.walk_done) begin
            if (last_part) begin
              state_next = S_IDLE;
            end else begin
              part_sel_next  = 1'b1;
              last_part_next = 1'b1;
              state_next     = S_SETUP;
            end
          end
        end
      end
      S_FLAT: begin
        if (stat.out_free) begin
          cmd.emit_flat = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      part_sel  <= 1'b0;
      last_part <= 1'b0;
    end else begin
      state     <= state_next;
      part_sel  <= part_sel_next;
      last_part <= last_part_next;
    end
  end
endmodule

@@ design/triangle_span_rasterizer.sv @@
// Triangle span rasterizer: one triangle request in, one span per covered row out,
// except that the split row of a split triangle gets one span from each part. A
// triangle is accepted, then classified; each division is issued to one shared
// radix-2 divider, and each part has a setup step before it emits its spans. A
// triangle with no flat edge needs one split-point division and two slope divisions
// for each of its two parts, a flat-edged one only the two slope divisions, and a
// zero-height one none; the span walk stalls while the span output is held off.
// One triangle is in work at a time; the last span may still wait in the output
// register while the next triangle is taken.
// Depends on tsr_pkg, tsr_tri_if, tsr_span_if, tsr_ctl, tsr_dp, tsr_div.
`timescale 1ns / 1ps
module triangle_span_rasterizer (
  input  logic        clk,
  input  logic        rst,
  tsr_tri_if.sink     tri_in,
  tsr_span_if.source  span_out
);
  tsr_pkg::cmd_t  cmd;
  tsr_pkg::stat_t stat;
  tsr_pkg::tri_t  tri_data;
  tsr_pkg::span_t span;
  logic           in_ready;
  logic           out_valid;

  // gather request fields
  always_comb begin
    tri_data.in_valid = tri_in.valid;
    tri_data.ax    = tri_in.ax;
    tri_data.ay    = tri_in.ay;
    tri_data.bx    = tri_in.bx;
    tri_data.by    = tri_in.by;
    tri_data.cx    = tri_in.cx;
    tri_data.cy    = tri_in.cy;
    tri_data.glyph = tri_in.glyph;
    tri_data.color = tri_in.color;
  end

  tsr_ctl u_ctl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (tri_data.in_valid),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  tsr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .tri_in    (tri_data),
    .out_ready (span_out.ready),
    .stat      (stat),
    .out_valid (out_valid),
    .span      (span)
  );

  // drive channels
  assign tri_in.ready        = in_ready;
  assign span_out.valid      = out_valid;
  assign span_out.row        = span.row;
  assign span_out.span_left  = span.span_left;
  assign span_out.span_right = span.span_right;
  assign span_out.span_empty = span.span_empty;
  assign span_out.fill_glyph = span.fill_glyph;
  assign span_out.fill_color = span.fill_color;
  assign span_out.last_span  = span.last_span;

`ifndef SYNTHESIS
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (tri_in.valid && tri_in.ready) |=> !tri_in.ready)
    else $error("triangle taken while previous one in work");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.emit_flat) |-> stat.out_free)
    else $error("span written over a waiting span");
  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !stat.div_busy)
    else $error("divider started while busy");
`endif
endmodule
